// ----- src/arr_pkg.sv -----
// Shared types and codes for the address range table.
package arr_pkg;

  localparam int AddrWidth   = 64;
  localparam int TagWidth    = 32;
  localparam int FuncWidth   = 2;
  localparam int StatusWidth = 3;

  typedef logic [AddrWidth-1:0]   addr_t;
  typedef logic [TagWidth-1:0]    tag_t;
  typedef logic [FuncWidth-1:0]   func_t;
  typedef logic [StatusWidth-1:0] status_t;

  // operation codes
  localparam func_t FN_INSERT = 2'd0;
  localparam func_t FN_LOOKUP = 2'd1;
  localparam func_t FN_CLEAR  = 2'd2;
  localparam func_t FN_UNUSED = 2'd3;  // ignored, no state change

  // result status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_INVERTED = 3'd1;
  localparam status_t ST_OVERLAP  = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_MISS     = 3'd4;

  // one stored range, inclusive bounds
  typedef struct packed {
    tag_t  tag;
    addr_t last;
    addr_t first;
  } entry_t;

  // compare unit results
  typedef struct packed {
    logic a_le_hi;  // a <= hi_bound
    logic b_ge_lo;  // b >= lo_bound
  } cmp_res_t;

endpackage

// ----- src/arr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module arr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/arr_cmp.sv -----
// Shared range compare unit: a <= hi_bound and b >= lo_bound.
module arr_cmp (
  input  arr_pkg::addr_t    a,
  input  arr_pkg::addr_t    b,
  input  arr_pkg::addr_t    lo_bound,
  input  arr_pkg::addr_t    hi_bound,
  output arr_pkg::cmp_res_t res
);
  import arr_pkg::*;

  always_comb begin
    res.a_le_hi = (a <= hi_bound);
    res.b_ge_lo = (b >= lo_bound);
  end

endmodule

// ----- src/address_range_table.sv -----
// Top level of the address range table: sequencer, entry RAM and compare unit.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser: func; tdata: start, end, tag, addr
//  m_axis   | out | m_axis_tvalid/tready    | tuser: status, hit; tdata: found_value
//
// Insert and lookup scan the stored ranges; one entry is compared per
// cycle against the single RAM read port through the one compare unit.
// Clear and unused codes skip the scan and go straight to the result.
// s_axis_tready is high only while the sequencer is idle; a finished word
// waits in the output register, so a new word can be taken meanwhile.
// Synchronous reset empties the table (fill count to zero); no RAM sweep.
module address_range_table #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  // input word
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // [1:0] func
  input  logic [223:0] s_axis_tdata,   // [63:0] range_start, [127:64] range_end,
                                       // [159:128] tag_value, [223:160] query_address
  // result word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [3:0]   m_axis_tuser,   // [2:0] status, [3] hit
  output logic [31:0]  m_axis_tdata    // [31:0] found_value
);
  import arr_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // RAM index width
  localparam int CW = $clog2(CAPACITY + 1);                   // fill count width

  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] S_INV  = 3'd1;  // inverted-range check
  localparam logic [2:0] S_SCAN = 3'd2;  // one stored entry per cycle
  localparam logic [2:0] S_INS  = 3'd3;  // full check and append
  localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

  logic [2:0]    state;
  logic [CW-1:0] count;   // number of valid entries
  logic [AW-1:0] idx;     // entry whose read data is on rd_data in S_SCAN

  // latched request
  func_t req_func;
  addr_t req_lo;
  addr_t req_hi;
  tag_t  req_tag;
  addr_t req_addr;

  // pending result
  status_t res_status;
  logic    res_hit;
  tag_t    res_value;

  // RAM and compare unit
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  entry_t        wr_entry;
  entry_t        rd_data;
  addr_t         cmp_a;
  addr_t         cmp_b;
  addr_t         cmp_hi;
  cmp_res_t      cmp_res;

  logic scan_match;
  logic scan_last;
  logic out_free;
  logic is_lookup;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign is_lookup     = (req_func == FN_LOOKUP);

  // In S_SCAN prefetch the following entry; elsewhere entry 0 is prefetched
  // so a scan can start in the next cycle.
  assign ram_raddr = (state == S_SCAN) ? AW'(idx + AW'(1)) : '0;
  assign ram_we    = (state == S_INS) && (count != CW'(CAPACITY));
  assign wr_entry  = '{tag: req_tag, last: req_hi, first: req_lo};

  arr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Operand select: a lookup tests addr in [first, last]; an insert tests
  // lo <= last && hi >= first; the inverted check reuses a <= hi_bound.
  always_comb begin
    cmp_a  = (state == S_SCAN && is_lookup) ? req_addr : req_lo;
    cmp_b  = (state == S_SCAN && is_lookup) ? req_addr : req_hi;
    cmp_hi = (state == S_INV) ? req_hi : rd_data.last;
  end

  arr_cmp u_cmp (
    .a        (cmp_a),
    .b        (cmp_b),
    .lo_bound (rd_data.first),
    .hi_bound (cmp_hi),
    .res      (cmp_res)
  );

  assign scan_match = cmp_res.a_le_hi && cmp_res.b_ge_lo;
  assign scan_last  = ((CW'(idx) + CW'(1)) == count);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (s_axis_tvalid) begin
            unique case (s_axis_tuser)
              FN_INSERT: state <= S_INV;
              FN_LOOKUP: state <= (count == '0) ? S_DONE : S_SCAN;
              FN_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_INV: begin
          if (!cmp_res.a_le_hi) begin
            state <= S_DONE;
          end else if (count == '0) begin
            state <= S_INS;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_match) begin
            state <= S_DONE;
          end else if (scan_last) begin
            state <= is_lookup ? S_DONE : S_INS;
          end else begin
            idx <= AW'(idx + AW'(1));
          end
        end
        S_INS: begin
          if (ram_we) begin
            count <= CW'(count + CW'(1));
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request latch and pending result (payload, no reset)
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_func <= s_axis_tuser;
      req_lo   <= s_axis_tdata[63:0];
      req_hi   <= s_axis_tdata[127:64];
      req_tag  <= s_axis_tdata[159:128];
      req_addr <= s_axis_tdata[223:160];
      // default result covers clear and unused codes
      res_status <= (s_axis_tuser == FN_LOOKUP && count == '0) ? ST_MISS : ST_OK;
      res_hit    <= 1'b0;
      res_value  <= '0;
    end
    if (state == S_INV && !cmp_res.a_le_hi) begin
      res_status <= ST_INVERTED;
    end
    if (state == S_SCAN) begin
      if (scan_match) begin
        if (is_lookup) begin
          res_status <= ST_OK;
          res_hit    <= 1'b1;
          res_value  <= rd_data.tag;
        end else begin
          res_status <= ST_OVERLAP;
        end
      end else if (scan_last && is_lookup) begin
        res_status <= ST_MISS;
      end
    end
    if (state == S_INS) begin
      res_status <= ram_we ? ST_OK : ST_FULL;
      res_hit    <= ram_we;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tuser <= {res_hit, res_status};
      m_axis_tdata <= res_value;
    end
  end

  // fill count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a clear empties the table
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_CLEAR |=> count == '0)
    else $error("clear did not empty table");

  // a hit always carries an ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == ST_OK)
    else $error("hit with non-ok status");

  // a nonzero value only comes with a hit
  a_value_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata != '0 |-> m_axis_tuser[3])
    else $error("found value without hit");

endmodule
